// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication failed");

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: sv/ioro_pkg.sv
// ----------------------------------------------------------------------------
// ioro_pkg
// Types and constants shared by the in-order reorder buffer modules.
// ----------------------------------------------------------------------------
package ioro_pkg;

    localparam int DEPTH     = 64;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int PTR_W     = SLOT_W + 1;
    localparam int PAYLOAD_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 2'd1;

    typedef enum logic [1:0] {
        ST_RELEASED  = 2'd0,
        ST_SLOT_FULL = 2'd1,
        ST_OUT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DRAIN,
        S_LOAD,
        S_SEND
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_in;
        logic load_single;
        logic commit;
        logic issue_read;
        logic load_drain;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic single_result;
        logic drain_hit;
        logic result_last;
    } sts_t;

endpackage

// File: sv/ioro_dp.sv
// ----------------------------------------------------------------------------
// ioro_dp
// Datapath: configuration, slot store, full flags, read pointer, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ioro_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic [ioro_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ioro_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic [ioro_pkg::SLOT_W-1:0]         in_slot,
    input  logic [ioro_pkg::PAYLOAD_W-1:0]      in_payload,
    input  ioro_pkg::cmd_t                      cmd,
    output ioro_pkg::sts_t                      sts,
    output logic [ioro_pkg::PAYLOAD_W-1:0]      out_payload,
    output logic [ioro_pkg::SLOT_W-1:0]         out_slot,
    output ioro_pkg::status_t                   out_status,
    output logic                                out_last,
    output logic                                out_done
);

    logic [ioro_pkg::PTR_W-1:0]     slots_eff_reg, slots_eff_next;
    logic                           bypass_reg;
    logic [ioro_pkg::PTR_W-1:0]     rp_reg;
    logic [ioro_pkg::DEPTH-1:0]     full_reg;

    logic [ioro_pkg::SLOT_W-1:0]    slot_in_reg;
    logic [ioro_pkg::PAYLOAD_W-1:0] pay_in_reg;
    logic [ioro_pkg::PAYLOAD_W-1:0] mem [ioro_pkg::DEPTH];
    logic [ioro_pkg::PAYLOAD_W-1:0] mem_q_reg;
    logic [ioro_pkg::SLOT_W-1:0]    rd_slot_reg;

    logic [ioro_pkg::PAYLOAD_W-1:0] out_pay_reg;
    logic [ioro_pkg::SLOT_W-1:0]    out_slot_reg;
    ioro_pkg::status_t              out_status_reg;
    logic                           out_last_reg;
    logic                           out_done_reg;

    logic range_err;
    logic full_err;
    logic drain_hit;
    logic run_done;

    // A count of zero behaves as one slot, anything above the depth as the depth.
    always_comb begin
        priority if (cfg_data == '0) begin
            slots_eff_next = ioro_pkg::PTR_W'(1);
        end else if (cfg_data > ioro_pkg::CFG_DAT_W'(ioro_pkg::DEPTH)) begin
            slots_eff_next = ioro_pkg::PTR_W'(ioro_pkg::DEPTH);
        end else begin
            slots_eff_next = ioro_pkg::PTR_W'(cfg_data);
        end
    end

    assign range_err = {1'b0, slot_in_reg} >= slots_eff_reg;
    assign full_err  = full_reg[slot_in_reg];
    assign drain_hit = (rp_reg < slots_eff_reg) && full_reg[rp_reg[ioro_pkg::SLOT_W-1:0]];
    assign run_done  = rp_reg >= slots_eff_reg;

    assign sts.single_result = bypass_reg || range_err || full_err;
    assign sts.drain_hit     = drain_hit;
    assign sts.result_last   = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_eff_reg <= ioro_pkg::PTR_W'(ioro_pkg::DEPTH);
            bypass_reg    <= 1'b0;
            rp_reg        <= '0;
            full_reg      <= '0;
        end else begin
            if (cfg_write && cfg_index == ioro_pkg::REG_SLOTS_IN_USE) begin
                // Writing the slot count starts a new run.
                slots_eff_reg <= slots_eff_next;
                rp_reg        <= '0;
                full_reg      <= '0;
            end else begin
                if (cmd.commit) begin
                    full_reg[slot_in_reg] <= 1'b1;
                end
                if (cmd.issue_read) begin
                    rp_reg <= rp_reg + ioro_pkg::PTR_W'(1);
                end
            end
            if (cfg_write && cfg_index == ioro_pkg::REG_BYPASS) begin
                bypass_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem[slot_in_reg] <= pay_in_reg;
        end
        if (cmd.issue_read) begin
            mem_q_reg <= mem[rp_reg[ioro_pkg::SLOT_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            slot_in_reg <= in_slot;
            pay_in_reg  <= in_payload;
        end
        if (cmd.issue_read) begin
            rd_slot_reg <= rp_reg[ioro_pkg::SLOT_W-1:0];
        end
        if (cmd.load_single) begin
            out_slot_reg <= slot_in_reg;
            out_last_reg <= 1'b1;
            out_done_reg <= run_done;
            priority if (bypass_reg) begin
                out_pay_reg    <= pay_in_reg;
                out_status_reg <= ioro_pkg::ST_RELEASED;
            end else if (range_err) begin
                out_pay_reg    <= '0;
                out_status_reg <= ioro_pkg::ST_OUT_RANGE;
            end else begin
                out_pay_reg    <= '0;
                out_status_reg <= ioro_pkg::ST_SLOT_FULL;
            end
        end else if (cmd.load_drain) begin
            // The pointer has already moved past the slot being released.
            out_pay_reg    <= mem_q_reg;
            out_slot_reg   <= rd_slot_reg;
            out_status_reg <= ioro_pkg::ST_RELEASED;
            out_last_reg   <= !drain_hit;
            out_done_reg   <= run_done;
        end
    end

    assign out_payload = out_pay_reg;
    assign out_slot    = out_slot_reg;
    assign out_status  = out_status_reg;
    assign out_last    = out_last_reg;
    assign out_done    = out_done_reg;

    `ASSERT_ALWAYS(a_rp_in_run, rp_reg <= slots_eff_reg, "read pointer beyond slots in use")
    `ASSERT_NEXT(a_read_was_full, cmd.issue_read, full_reg[rd_slot_reg])

endmodule

// File: sv/ioro_ctrl.sv
// ----------------------------------------------------------------------------
// ioro_ctrl
// Controller: sequences check, commit, drain and result handoff per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ioro_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  ioro_pkg::sts_t  sts,
    output ioro_pkg::cmd_t  cmd
);

    ioro_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ioro_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ioro_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ioro_pkg::S_CHECK;
                end
            end
            ioro_pkg::S_CHECK: begin
                if (sts.single_result) begin
                    state_next = ioro_pkg::S_SEND;
                end else begin
                    state_next = ioro_pkg::S_DRAIN;
                end
            end
            ioro_pkg::S_DRAIN: begin
                if (sts.drain_hit) begin
                    state_next = ioro_pkg::S_LOAD;
                end else begin
                    state_next = ioro_pkg::S_IDLE;
                end
            end
            ioro_pkg::S_LOAD: begin
                state_next = ioro_pkg::S_SEND;
            end
            ioro_pkg::S_SEND: begin
                if (m_tready) begin
                    state_next = sts.result_last ? ioro_pkg::S_IDLE : ioro_pkg::S_DRAIN;
                end
            end
            default: begin
                state_next = ioro_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ioro_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
            end
            ioro_pkg::S_CHECK: begin
                cmd.load_single = sts.single_result;
                cmd.commit      = !sts.single_result;
            end
            ioro_pkg::S_DRAIN: begin
                cmd.issue_read = sts.drain_hit;
            end
            ioro_pkg::S_LOAD: begin
                cmd.load_drain = 1'b1;
            end
            ioro_pkg::S_SEND: begin
                m_tvalid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_last_frees_input, m_tvalid && m_tready && sts.result_last, s_tready)
    `ASSERT_IMPLIES(a_one_side_busy, s_tready, !m_tvalid)

endmodule

// File: sv/in_order_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// in_order_reorder_buffer_unit
// Reorder buffer that releases out-of-order task completions in slot order.
// ----------------------------------------------------------------------------
// Each request on the s_ channel commits a payload handle to a task slot. When
// the slot at the read pointer is full, that slot and the full slots directly
// after it are released on the m_ channel in slot order; m_tlast marks the final
// result of the request. A second commit to a full slot or a slot beyond the
// count in use yields one error result (m_tuser holds the status). In bypass
// mode the payload goes straight out. The cfg_ channel writes the slot count
// (index 0, which also empties all slots and rewinds the pointer) and bypass
// (index 1); cfg_ready is always high; writes must be made while the block is
// idle, which the block does not enforce. One request is handled at a time.
// An error or bypass result passes the check and send states; a commit passes
// check, drain, load and send, and each further release drain, load and send,
// set by the registered read of the slot store. A commit that releases nothing
// returns from drain to idle. A stalled m_tready holds the result and keeps
// s_tready low. Reset empties all slots, sets the count to 64 and clears bypass.
// ----------------------------------------------------------------------------
module in_order_reorder_buffer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ioro_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ioro_pkg::CFG_DAT_W-1:0]     cfg_data,
    // Commit requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [39:0]                        s_tdata,  // task_slot[5:0], payload[37:6]
    // Released results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // out_payload[31:0], out_slot[37:32],
                                                         // all_done[38]
    output logic [1:0]                         m_tuser,  // status[1:0]
    output logic                               m_tlast
);

    ioro_pkg::cmd_t                 cmd;
    ioro_pkg::sts_t                 sts;
    logic [ioro_pkg::PAYLOAD_W-1:0] out_payload;
    logic [ioro_pkg::SLOT_W-1:0]    out_slot;
    ioro_pkg::status_t              out_status;
    logic                           out_done;

    assign cfg_ready = 1'b1;

    ioro_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ioro_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_slot     (s_tdata[5:0]),
        .in_payload  (s_tdata[37:6]),
        .cmd         (cmd),
        .sts         (sts),
        .out_payload (out_payload),
        .out_slot    (out_slot),
        .out_status  (out_status),
        .out_last    (m_tlast),
        .out_done    (out_done)
    );

    assign m_tdata = {1'b0, out_done, out_slot, out_payload};
    assign m_tuser = out_status;

endmodule
